// ===== rtl/recloser_trip_lockout_control_core_macros.svh =====
// ----------------------------------------------------------------------------
// Recloser controller assertion macros
// Shared property shorthands for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef RECLOSER_TRIP_LOCKOUT_CONTROL_CORE_MACROS_SVH
`define RECLOSER_TRIP_LOCKOUT_CONTROL_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define RTLC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define RTLC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rtlc_pkg.sv =====
// ----------------------------------------------------------------------------
// Recloser controller package
// Widths, register indexes, state and beat types, saturating helpers.
// ----------------------------------------------------------------------------
package rtlc_pkg;

	localparam int TIME_W = 32;
	localparam int CNT_W  = 15;
	localparam int DLY_W  = 16;

	localparam logic [TIME_W-1:0] TIME_MASK = '1;
	localparam logic [TIME_W-1:0] TIME_LAST = TIME_MASK - TIME_W'(1);
	localparam logic [CNT_W-1:0]  TRY_MAX   = '1;

	// configuration register indexes
	localparam logic CFG_RECLOSE_DELAY = 1'b0;
	localparam logic CFG_TRY_LIMIT     = 1'b1;

	localparam logic [DLY_W-1:0] RECLOSE_DELAY_RST = 16'd3;
	localparam logic [CNT_W-1:0] TRY_LIMIT_RST     = 15'd5;

	typedef logic [TIME_W-1:0] time_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef struct packed {
		logic  closed;
		logic  lock_pend;
		time_t retry_dl;
		time_t lock_dl;
		cnt_t  total;
		cnt_t  evt;
	} state_t;

	typedef struct packed {
		time_t            now;
		logic             fault;
		logic             ev;
		logic [DLY_W-1:0] draw;
	} item_t;

	typedef struct packed {
		logic             line_closed;
		logic             locked_out;
		logic [31:0]      next_wake;
		cnt_t             tries_total;
		cnt_t             tries_current;
	} result_t;

	typedef struct packed {
		logic [DLY_W-1:0] delay;
		cnt_t             limit;
	} cfg_t;

	// now + span, clamped below the reserved all-ones code
	function automatic time_t sat_deadline(time_t now, logic [DLY_W-1:0] span);
		logic [TIME_W:0] sum;
		sum = {1'b0, now} + (TIME_W+1)'(span);
		if (sum > {1'b0, TIME_LAST}) begin
			return TIME_LAST;
		end
		return sum[TIME_W-1:0];
	endfunction

	function automatic cnt_t bump(cnt_t c);
		return (c < TRY_MAX) ? c + CNT_W'(1) : TRY_MAX;
	endfunction

endpackage

// ===== rtl/rtlc_next.sv =====
// ----------------------------------------------------------------------------
// Recloser controller evaluation logic
// Next state and result for one evaluation beat under event or legacy rules.
// ----------------------------------------------------------------------------
module rtlc_next (
	input  rtlc_pkg::state_t  st,
	input  rtlc_pkg::item_t   item,
	input  rtlc_pkg::cfg_t    cfg,
	output rtlc_pkg::state_t  st_nxt,
	output rtlc_pkg::result_t res
);

	rtlc_pkg::time_t dl_retry;
	rtlc_pkg::time_t dl_lock;
	rtlc_pkg::time_t wake;
	rtlc_pkg::cnt_t  evt_inc;
	logic            expired;

	assign dl_retry = rtlc_pkg::sat_deadline(item.now, cfg.delay);
	assign dl_lock  = rtlc_pkg::sat_deadline(item.now, item.draw);
	assign evt_inc  = rtlc_pkg::bump(st.evt);
	assign expired  = st.lock_pend && (st.lock_dl <= item.now);

	always_comb begin
		st_nxt = st;
		wake   = rtlc_pkg::TIME_MASK;
		if (expired) begin
			// lockout over: close and clear the rule set's counter
			st_nxt.lock_pend = 1'b0;
			st_nxt.lock_dl   = '0;
			st_nxt.retry_dl  = '0;
			st_nxt.closed    = 1'b1;
			if (item.ev) begin
				st_nxt.evt = '0;
			end else begin
				st_nxt.total = '0;
			end
		end else if (st.lock_pend) begin
			if (item.ev) begin
				st_nxt.closed = 1'b0;
			end
			wake = st.lock_dl;
		end else if (item.ev) begin
			if (!st.closed) begin
				if (st.retry_dl <= item.now) begin
					st_nxt.total = rtlc_pkg::bump(st.total);
					st_nxt.evt   = evt_inc;
					if (evt_inc > cfg.limit) begin
						st_nxt.retry_dl  = '0;
						st_nxt.lock_dl   = dl_lock;
						st_nxt.lock_pend = 1'b1;
						wake             = dl_lock;
					end else begin
						st_nxt.retry_dl = dl_retry;
						wake            = dl_retry;
					end
				end else begin
					wake = st.retry_dl;
				end
			end else begin
				st_nxt.closed    = 1'b0;
				st_nxt.evt       = '0;
				st_nxt.lock_dl   = '0;
				st_nxt.retry_dl  = dl_retry;
				wake             = dl_retry;
			end
		end else begin
			if (st.closed && item.fault) begin
				st_nxt.closed   = 1'b0;
				st_nxt.retry_dl = dl_retry;
				wake            = dl_retry;
			end else if (!st.closed && (item.now >= st.retry_dl)) begin
				if (item.fault) begin
					if (cfg.limit > st.total) begin
						st_nxt.total    = rtlc_pkg::bump(st.total);
						st_nxt.retry_dl = dl_retry;
						wake            = dl_retry;
					end else begin
						st_nxt.lock_dl   = dl_lock;
						st_nxt.lock_pend = 1'b1;
						wake             = dl_lock;
					end
				end else begin
					st_nxt.closed = 1'b1;
				end
			end else if (st.retry_dl > item.now) begin
				wake = st.retry_dl;
			end else begin
				st_nxt.evt    = '0;
				st_nxt.total  = '0;
				st_nxt.closed = 1'b1;
			end
		end
	end

	always_comb begin
		res.line_closed   = st_nxt.closed;
		res.locked_out    = st_nxt.lock_pend;
		res.next_wake     = 32'(wake);
		res.tries_total   = st_nxt.total;
		res.tries_current = st_nxt.evt;
	end

endmodule

// ===== rtl/recloser_trip_lockout_control_core.sv =====
// ----------------------------------------------------------------------------
// Recloser trip and lockout controller
// Evaluates one time tick per beat: trip on fault, timed reclose, lockout.
// ----------------------------------------------------------------------------
// Beats pass through the input register and then the result register.
// Throughput: one beat per cycle unless the result side stalls; the state loop closes
//   through one pass of compares and two saturating adders between the registers.
// Reset: arst_n clears the recloser state to closed, no deadlines, counters
//   zero, and loads reclose delay 3 s and try limit 5.
module recloser_trip_lockout_control_core (
	input  logic        clk,
	input  logic        arst_n,
	// evaluation beats in
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] now_time,
	input  logic        fault_seen,
	input  logic        event_mode,
	input  logic [15:0] lockout_seconds,
	// result beats out
	output logic        out_valid,
	input  logic        out_stall,
	output logic        line_closed,
	output logic        locked_out,
	output logic [31:0] next_wake,
	output logic [14:0] tries_total,
	output logic [14:0] tries_current,
	// configuration writes
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	rtlc_pkg::cfg_t    cfg_q;
	rtlc_pkg::state_t  state_q;
	rtlc_pkg::state_t  state_nxt;
	rtlc_pkg::item_t   item_s1;
	logic              valid_s1;
	rtlc_pkg::result_t res_nxt;
	rtlc_pkg::result_t res_q;
	logic              out_valid_q;
	logic              in_take;
	logic              advance;

	// The evaluation in stage one may retire when the result register is
	// empty or its beat leaves this cycle; stall the input only when a beat
	// sits in stage one and cannot retire.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// Configuration registers: the user must write them only while idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay <= rtlc_pkg::RECLOSE_DELAY_RST;
			cfg_q.limit <= rtlc_pkg::TRY_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rtlc_pkg::CFG_RECLOSE_DELAY: cfg_q.delay <= cfg_data;
				rtlc_pkg::CFG_TRY_LIMIT:     cfg_q.limit <= cfg_data[rtlc_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register: capture the beat; time is masked to the time width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.now   <= rtlc_pkg::TIME_W'(now_time);
			item_s1.fault <= fault_seen;
			item_s1.ev    <= event_mode;
			item_s1.draw  <= lockout_seconds;
		end
	end

	// One evaluation pass: next state and the result it reports.
	rtlc_next u_next (
		.st     (state_q),
		.item   (item_s1),
		.cfg    (cfg_q),
		.st_nxt (state_nxt),
		.res    (res_nxt)
	);

	// Recloser state: advance together with the result register so the
	// next beat in stage one sees the updated state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.closed    <= 1'b1;
			state_q.lock_pend <= 1'b0;
			state_q.retry_dl  <= '0;
			state_q.lock_dl   <= '0;
			state_q.total     <= '0;
			state_q.evt       <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register: hold while stalled, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign line_closed   = res_q.line_closed;
	assign locked_out    = res_q.locked_out;
	assign next_wake     = res_q.next_wake;
	assign tries_total   = res_q.tries_total;
	assign tries_current = res_q.tries_current;

endmodule

// ===== rtl/rtlc_checker.sv =====
// ----------------------------------------------------------------------------
// Recloser controller port checker
// Watches the top level ports for handshake and lockout consistency.
// ----------------------------------------------------------------------------
`include "recloser_trip_lockout_control_core_macros.svh"

module rtlc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        line_closed,
	input logic        locked_out,
	input logic [31:0] next_wake,
	input logic [14:0] tries_total,
	input logic [14:0] tries_current
);

	`RTLC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped while stalled")
	`RTLC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(next_wake) && $stable(tries_total) && $stable(tries_current) && $stable(line_closed) && $stable(locked_out), "stalled result changed")
	`RTLC_ASSERT_NOW(a_lock_open, out_valid && locked_out, !line_closed, "locked out while closed")
	`RTLC_ASSERT_NOW(a_lock_wake, out_valid && locked_out, next_wake != 32'hFFFF_FFFF, "lockout without a wake time")

endmodule

bind recloser_trip_lockout_control_core rtlc_checker u_rtlc_checker (.*);

// ===== verif/recloser_trip_lockout_control_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Recloser trip and lockout controller testbench
// Drives evaluation ticks with random gaps and result backpressure, predicts
// every status beat from a local model of the reclose rules and compares it
// field by field, across several reclose delay and try limit settings.
// ----------------------------------------------------------------------------
module recloser_trip_lockout_control_core_tb;

	// highest legal time; all ones is reserved for "never"
	localparam rtlc_pkg::time_t TOP_TIME = 32'hFFFF_FFFE;
	localparam rtlc_pkg::time_t NEVER    = 32'hFFFF_FFFF;
	localparam int    MAX_SHOWN = 200;

	// settings walked by the random phases, element 0 first
	localparam logic [4:0][15:0] PH_DELAY = {16'd2, 16'd5, 16'd65535, 16'd1, 16'd0};
	localparam logic [4:0][14:0] PH_LIMIT = {15'd4, 15'd32767, 15'd2, 15'd1, 15'd0};
	localparam int PH_BEATS = 250;

	// one row of the directed plan: tick, and optionally a hand-written status
	typedef struct packed {
		rtlc_pkg::item_t   tick;
		logic              fixed;
		rtlc_pkg::result_t want;
	} tick_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] now_time;
	logic        fault_seen;
	logic        event_mode;
	logic [15:0] lockout_seconds;
	logic        out_valid;
	logic        out_stall;
	logic        line_closed;
	logic        locked_out;
	logic [31:0] next_wake;
	logic [14:0] tries_total;
	logic [14:0] tries_current;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	// local copy of the recloser state and its two settings
	logic                       rc_closed;
	logic                       lock_pending;
	rtlc_pkg::time_t            retry_at;
	rtlc_pkg::time_t            lockout_at;
	rtlc_pkg::cnt_t             total_cnt;
	rtlc_pkg::cnt_t             event_cnt;
	logic [rtlc_pkg::DLY_W-1:0] cfg_delay;
	rtlc_pkg::cnt_t             cfg_limit;

	// status beats still owed by the block, oldest first
	rtlc_pkg::result_t awaited_status[$];
	int      fails;

	// idling controls shared by the sender and the result stall process
	bit idle_on;
	bit stall_on;
	int stall_left;

	tick_row_t plan [25];

	recloser_trip_lockout_control_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.now_time       (now_time),
		.fault_seen     (fault_seen),
		.event_mode     (event_mode),
		.lockout_seconds(lockout_seconds),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.line_closed    (line_closed),
		.locked_out     (locked_out),
		.next_wake      (next_wake),
		.tries_total    (tries_total),
		.tries_current  (tries_current),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// now + span, held below the "never" code
	function automatic rtlc_pkg::time_t deadline_after(rtlc_pkg::time_t base,
			logic [rtlc_pkg::DLY_W-1:0] span);
		logic [32:0] sum;
		sum = {1'b0, base} + {17'd0, span};
		if (sum > {1'b0, TOP_TIME}) begin
			return TOP_TIME;
		end
		return sum[31:0];
	endfunction

	function automatic rtlc_pkg::cnt_t count_up(rtlc_pkg::cnt_t c);
		return (c == 15'h7FFF) ? c : c + 15'd1;
	endfunction

	// Advance the local recloser state by one evaluation tick and return
	// the status beat the block must produce for it.
	function automatic rtlc_pkg::result_t recloser_tick(rtlc_pkg::item_t it);
		rtlc_pkg::result_t r;
		rtlc_pkg::time_t   wake;
		wake = NEVER;
		if (it.ev) begin
			// reliability event rules: the fault flag plays no part
			if (lock_pending && lockout_at <= it.now) begin
				lock_pending = 1'b0;
				lockout_at   = '0;
				retry_at     = '0;
				event_cnt    = '0;
				rc_closed    = 1'b1;
			end else if (lock_pending) begin
				rc_closed = 1'b0;
				wake      = lockout_at;
			end else if (!rc_closed) begin
				if (retry_at <= it.now) begin
					total_cnt = count_up(total_cnt);
					event_cnt = count_up(event_cnt);
					if (event_cnt > cfg_limit) begin
						retry_at     = '0;
						lockout_at   = deadline_after(it.now, it.draw);
						lock_pending = 1'b1;
						wake         = lockout_at;
					end else begin
						retry_at = deadline_after(it.now, cfg_delay);
						wake     = retry_at;
					end
				end else begin
					wake = retry_at;
				end
			end else begin
				rc_closed    = 1'b0;
				event_cnt    = '0;
				lock_pending = 1'b0;
				lockout_at   = '0;
				retry_at     = deadline_after(it.now, cfg_delay);
				wake         = retry_at;
			end
		end else begin
			// legacy contact rules
			if (lock_pending && lockout_at <= it.now) begin
				lock_pending = 1'b0;
				lockout_at   = '0;
				retry_at     = '0;
				total_cnt    = '0;
				rc_closed    = 1'b1;
			end else if (lock_pending) begin
				wake = lockout_at;
			end else if (rc_closed && it.fault) begin
				rc_closed = 1'b0;
				retry_at  = deadline_after(it.now, cfg_delay);
				wake      = retry_at;
			end else if (!rc_closed && it.now >= retry_at) begin
				if (!it.fault) begin
					rc_closed = 1'b1;
				end else if (cfg_limit > total_cnt) begin
					total_cnt = count_up(total_cnt);
					retry_at  = deadline_after(it.now, cfg_delay);
					wake      = retry_at;
				end else begin
					// lockout keeps the line open and the old retry deadline
					lockout_at   = deadline_after(it.now, it.draw);
					lock_pending = 1'b1;
					wake         = lockout_at;
				end
			end else if (retry_at > it.now) begin
				wake = retry_at;
			end else begin
				event_cnt = '0;
				total_cnt = '0;
				rc_closed = 1'b1;
			end
		end
		r.line_closed   = rc_closed;
		r.locked_out    = lock_pending;
		r.next_wake     = wake;
		r.tries_total   = total_cnt;
		r.tries_current = event_cnt;
		return r;
	endfunction

	// Present one tick, hold it until the block takes it, then log what the
	// block owes for it: the hand-written status if given, else the prediction.
	task automatic send_beat(input rtlc_pkg::item_t it, input logic fixed,
			input rtlc_pkg::result_t want);
		logic              took;
		rtlc_pkg::result_t guess;
		in_valid        <= 1'b1;
		now_time        <= it.now;
		fault_seen      <= it.fault;
		event_mode      <= it.ev;
		lockout_seconds <= it.draw;
		do begin
			@(negedge clk);
			took = !in_stall;
			@(posedge clk);
		end while (!took);
		guess = recloser_tick(it);
		awaited_status.push_back(fixed ? want : guess);
	endtask

	// Drop valid for a random burst, but only while idling is allowed.
	task automatic idle_gap();
		int n;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 9);
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Stop sending and let every owed status beat come back.
	task automatic settle();
		in_valid <= 1'b0;
		while (awaited_status.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Both registers are written, reclose delay first and then try limit, while the block is idle.
	task automatic set_config(input logic [15:0] delay, input rtlc_pkg::cnt_t limit);
		cfg_we    <= 1'b1;
		cfg_index <= rtlc_pkg::CFG_RECLOSE_DELAY;
		cfg_data  <= delay;
		@(posedge clk);
		cfg_delay = delay;
		cfg_index <= rtlc_pkg::CFG_TRY_LIMIT;
		cfg_data  <= {1'b0, limit};
		@(posedge clk);
		cfg_limit = limit;
		cfg_we <= 1'b0;
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			fails++;
			if (fails <= MAX_SHOWN) begin
				$display("%0t ns: %s mismatch, expected %0h actual %0h",
					$time, name, want, got);
			end
		end
	endtask

	// Sample the result side mid-cycle: the beat is taken at the next rising
	// edge and nothing on the port moves before then.
	always @(negedge clk) begin : status_check
		rtlc_pkg::result_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (awaited_status.size() == 0) begin
				fails++;
				if (fails <= MAX_SHOWN) begin
					$display("%0t ns: status beat with none expected, expected none actual %0h",
						$time, {line_closed, locked_out, next_wake, tries_total, tries_current});
				end
			end else begin
				want = awaited_status.pop_front();
				compare_field("line_closed", 32'(want.line_closed), 32'(line_closed));
				compare_field("locked_out", 32'(want.locked_out), 32'(locked_out));
				compare_field("next_wake", want.next_wake, next_wake);
				compare_field("tries_total", 32'(want.tries_total), 32'(tries_total));
				compare_field("tries_current", 32'(want.tries_current), 32'(tries_current));
			end
		end
	end

	// Result backpressure: random stall bursts while allowed.
	initial begin
		out_stall  = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if (stall_on && $urandom_range(0, 5) == 0) begin
					stall_left = $urandom_range(1, 9);
				end
			end
		end
	end

	// Hard stop in case the block hangs on a handshake.
	initial begin
		#20_000_000;
		$display("** recloser_trip_lockout_control_core: FAILED **");
		$finish;
	end

	initial begin : stimulus
		rtlc_pkg::item_t it;
		rtlc_pkg::time_t t_now;
		logic [32:0]     aim;
		logic            mode_now;
		int              roll;
		int              w;

		arst_n          = 1'b0;
		in_valid        = 1'b0;
		now_time        = '0;
		fault_seen      = 1'b0;
		event_mode      = 1'b0;
		lockout_seconds = '0;
		cfg_we          = 1'b0;
		cfg_index       = rtlc_pkg::CFG_RECLOSE_DELAY;
		cfg_data        = '0;
		fails           = 0;
		idle_on         = 1'b1;
		stall_on        = 1'b1;

		// reset view of the recloser: closed, nothing scheduled, default settings
		rc_closed    = 1'b1;
		lock_pending = 1'b0;
		retry_at     = '0;
		lockout_at   = '0;
		total_cnt    = '0;
		event_cnt    = '0;
		cfg_delay    = 16'd3;
		cfg_limit    = 15'd5;

		// Directed plan under the reset settings (3 s delay, 5 tries).
		// Legacy: idle tick, trip, wait, five retries, lockout, unlock.
		plan[0]  = '{'{32'd0, 1'b0, 1'b0, 16'd0}, 1'b1, '{1'b1, 1'b0, NEVER, 15'd0, 15'd0}};
		plan[1]  = '{'{32'd10, 1'b1, 1'b0, 16'hFFFF}, 1'b1,
			'{1'b0, 1'b0, 32'd13, 15'd0, 15'd0}};
		plan[2]  = '{'{32'd11, 1'b1, 1'b0, 16'd0}, 1'b0, '0};
		plan[3]  = '{'{32'd13, 1'b1, 1'b0, 16'd0}, 1'b0, '0};
		plan[4]  = '{'{32'd16, 1'b1, 1'b0, 16'd0}, 1'b0, '0};
		plan[5]  = '{'{32'd19, 1'b1, 1'b0, 16'd0}, 1'b0, '0};
		plan[6]  = '{'{32'd22, 1'b1, 1'b0, 16'd0}, 1'b0, '0};
		plan[7]  = '{'{32'd25, 1'b1, 1'b0, 16'd0}, 1'b0, '0};
		plan[8]  = '{'{32'd28, 1'b1, 1'b0, 16'd100}, 1'b0, '0};
		plan[9]  = '{'{32'd50, 1'b0, 1'b0, 16'd0}, 1'b0, '0};
		plan[10] = '{'{32'd128, 1'b0, 1'b0, 16'd0}, 1'b1, '{1'b1, 1'b0, NEVER, 15'd0, 15'd0}};
		// legacy trip that clears on the first reclose
		plan[11] = '{'{32'd200, 1'b1, 1'b0, 16'd0}, 1'b0, '0};
		plan[12] = '{'{32'd203, 1'b0, 1'b0, 16'd0}, 1'b0, '0};
		// event rules: open, six tries, lockout with a zero draw, unlock
		plan[13] = '{'{32'd300, 1'b0, 1'b1, 16'd0}, 1'b0, '0};
		plan[14] = '{'{32'd303, 1'b1, 1'b1, 16'd0}, 1'b0, '0};
		plan[15] = '{'{32'd306, 1'b0, 1'b1, 16'd0}, 1'b0, '0};
		plan[16] = '{'{32'd309, 1'b1, 1'b1, 16'd0}, 1'b0, '0};
		plan[17] = '{'{32'd312, 1'b0, 1'b1, 16'd0}, 1'b0, '0};
		plan[18] = '{'{32'd315, 1'b1, 1'b1, 16'd0}, 1'b0, '0};
		plan[19] = '{'{32'd318, 1'b0, 1'b1, 16'd0}, 1'b0, '0};
		plan[20] = '{'{32'd318, 1'b0, 1'b1, 16'd0}, 1'b0, '0};
		// top of the time range: retry deadline clamps below "never"
		plan[21] = '{'{TOP_TIME, 1'b1, 1'b1, 16'd0}, 1'b1,
			'{1'b0, 1'b0, TOP_TIME, 15'd6, 15'd0}};
		plan[22] = '{'{32'd5, 1'b0, 1'b0, 16'd0}, 1'b0, '0};
		// legacy lockout at the top with the largest draw, then its unlock
		plan[23] = '{'{TOP_TIME, 1'b1, 1'b0, 16'hFFFF}, 1'b0, '0};
		plan[24] = '{'{TOP_TIME, 1'b0, 1'b0, 16'd0}, 1'b0, '0};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < 25; r++) begin
			send_beat(plan[r].tick, plan[r].fixed, plan[r].want);
			idle_gap();
		end

		// Largest try limit: event rules open the line, then retry on every tick and
		// never lock out; a few legacy ticks then keep retrying against the same limit.
		settle();
		idle_on  = 1'b0;
		stall_on = 1'b0;
		set_config(16'd1, 15'd32767);
		t_now = 32'd1000;
		for (int n = 0; n < 20; n++) begin
			it = '{t_now, 1'b0, 1'b1, 16'd5};
			send_beat(it, 1'b0, '0);
			t_now++;
		end
		for (int n = 0; n < 4; n++) begin
			it = '{t_now, 1'b1, 1'b0, 16'd7};
			send_beat(it, 1'b0, '0);
			t_now++;
		end

		// Random phases. Most ticks land on or next to the pending deadline so
		// that fault episodes run all the way through retries and lockouts;
		// the rest wander in time, jump to random or top-of-range times, and
		// switch rule sets.
		mode_now = 1'b0;
		for (int ph = 0; ph < 5; ph++) begin
			settle();
			set_config(PH_DELAY[ph], PH_LIMIT[ph]);
			if (ph == 0) begin
				t_now = '0;
			end
			for (int n = 0; n < PH_BEATS; n++) begin
				if (n % 50 == 0) begin
					idle_on = ($urandom_range(0, 3) != 0);
				end
				// quiet tail: no gaps and no stalls for the last beats of the run
				if (ph == 4 && n >= 100) begin
					idle_on = 1'b0;
				end
				stall_on = idle_on;

				roll = $urandom_range(0, 99);
				if (roll < 6) begin
					t_now = $urandom;
					if (t_now == NEVER) begin
						t_now = TOP_TIME;
					end
				end else if (roll < 10) begin
					t_now = TOP_TIME - $urandom_range(0, 20);
				end else if (roll < 70 && (lock_pending || !rc_closed)) begin
					aim = {1'b0, lock_pending ? lockout_at : retry_at} + $urandom_range(0, 3);
					if (aim != 0) begin
						aim = aim - 33'd1;
					end
					if (aim > {1'b0, TOP_TIME}) begin
						aim = {1'b0, TOP_TIME};
					end
					t_now = aim[31:0];
				end else begin
					aim = {1'b0, t_now} + $urandom_range(0, 4);
					if (aim > {1'b0, TOP_TIME}) begin
						aim = {1'b0, TOP_TIME};
					end
					t_now = aim[31:0];
				end
				if ($urandom_range(0, 29) == 0) begin
					mode_now = !mode_now;
				end

				it.now   = t_now;
				it.fault = ($urandom_range(0, 9) < 7);
				it.ev    = mode_now;
				it.draw  = $urandom_range(0, 1) ? 16'($urandom_range(0, 8)) : 16'($urandom);
				send_beat(it, 1'b0, '0);

				// now and then hold the sender until the block has caught up
				if (idle_on && $urandom_range(0, 99) == 0) begin
					settle();
				end else begin
					idle_gap();
				end
			end
		end

		// Drain: wait for the last status beats, then watch for strays.
		in_valid <= 1'b0;
		for (w = 0; w < 2000 && awaited_status.size() != 0; w++) @(posedge clk);
		repeat (8) @(posedge clk);
		if (awaited_status.size() != 0) begin
			fails++;
			$display("%0t ns: status beats never delivered, expected 0 actual %0d",
				$time, awaited_status.size());
		end

		if (fails == 0) begin
			$display("** recloser_trip_lockout_control_core: PASSED **");
		end else begin
			$display("** recloser_trip_lockout_control_core: FAILED **");
		end
		$finish;
	end

endmodule
